// File: src/lzfd_pkg.sv
// Shared types and constants for the LZF container stream deframer.
package lzfd_pkg;

    typedef enum logic [2:0] {
        PH_HDR1 = 3'd0,
        PH_HDR2 = 3'd1,
        PH_HDR3 = 3'd2,
        PH_DATA = 3'd3,
        PH_WAIT = 3'd4,
        PH_EOF  = 3'd5,
        PH_ERR  = 3'd6
    } lzfd_phase_t;

    typedef enum logic [1:0] {
        BK_STORED  = 2'd0,
        BK_LZF     = 2'd1,
        BK_TRAILER = 2'd2
    } lzfd_block_kind_t;

    localparam logic [1:0] OUT_NONE   = 2'd0;
    localparam logic [1:0] OUT_STORED = 2'd1;
    localparam logic [1:0] OUT_LZF    = 2'd2;

    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_CRC_OK  = 2'd1;
    localparam logic [1:0] ST_EOF     = 2'd2;
    localparam logic [1:0] ST_ERROR   = 2'd3;

    localparam logic [7:0]  MARK_Z       = 8'h5A;
    localparam logic [7:0]  MARK_V       = 8'h56;
    localparam logic [7:0]  TYPE_STORED  = 8'h00;
    localparam logic [7:0]  TYPE_LZF     = 8'h01;
    localparam logic [7:0]  TYPE_TRAILER = 8'h30;
    localparam logic [7:0]  END_MARK     = 8'h00;
    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       last_returned;
    } lzfd_in_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  out_byte;
        logic        block_end;
        logic [15:0] expected_size;
        logic [1:0]  status;
    } lzfd_out_t;

endpackage

// File: src/lzfd_crc_byte.sv
// Reflected CRC-32 update by one byte.
module lzfd_crc_byte (
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [31:0] crc_out
);
    import lzfd_pkg::*;

    always_comb begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data_in};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        crc_out = c;
    end

endmodule

// File: src/lzfd_parser.sv
// Header parser state and per-beat decode step.
module lzfd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  lzfd_pkg::lzfd_in_t  item,
    output lzfd_pkg::lzfd_out_t result
);
    import lzfd_pkg::*;

    lzfd_phase_t      phase_reg, phase_next;
    logic [31:0]      header_shift_reg, header_shift_next;
    logic [2:0]       header_count_reg, header_count_next;
    lzfd_block_kind_t block_kind_reg, block_kind_next;
    logic [15:0]      payload_left_reg, payload_left_next;
    logic [15:0]      block_usize_reg, block_usize_next;
    logic [16:0]      returned_count_reg, returned_count_next;
    logic [31:0]      crc_reg, crc_next;

    logic [31:0] crc_upd;
    logic [31:0] shifted;
    logic [2:0]  count_inc;
    logic [16:0] ret_inc;
    logic [15:0] left_dec;
    logic        crc_ok;
    logic        lzf_active;

    lzfd_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (item.data_byte),
        .crc_out (crc_upd)
    );

    assign shifted    = {header_shift_reg[23:0], item.data_byte};
    assign count_inc  = header_count_reg + 3'd1;
    assign ret_inc    = returned_count_reg + 17'd1;
    assign left_dec   = payload_left_reg - 16'd1;
    assign lzf_active = (block_kind_reg == BK_LZF) &&
                        (phase_reg == PH_DATA || phase_reg == PH_WAIT);

    always_comb begin
        phase_next          = phase_reg;
        header_shift_next   = header_shift_reg;
        header_count_next   = header_count_reg;
        block_kind_next     = block_kind_reg;
        payload_left_next   = payload_left_reg;
        block_usize_next    = block_usize_reg;
        returned_count_next = returned_count_reg;
        crc_next            = crc_reg;
        crc_ok              = 1'b0;
        result.out_kind     = OUT_NONE;
        result.out_byte     = 8'd0;
        result.block_end    = 1'b0;

        if (phase_reg == PH_ERR) begin
            // sticky
        end else if (phase_reg == PH_EOF) begin
            phase_next        = PH_ERR;
            payload_left_next = 16'd0;
        end else if (item.mode) begin
            if (!lzf_active || returned_count_reg >= {1'b0, block_usize_reg}) begin
                phase_next        = PH_ERR;
                payload_left_next = 16'd0;
            end else begin
                crc_next            = crc_upd;
                returned_count_next = ret_inc;
                if (item.last_returned) begin
                    if (phase_reg == PH_WAIT && ret_inc == {1'b0, block_usize_reg}) begin
                        phase_next = PH_HDR1;
                    end else begin
                        phase_next        = PH_ERR;
                        payload_left_next = 16'd0;
                    end
                end
            end
        end else begin
            unique case (phase_reg)
                PH_HDR1: begin
                    if (item.data_byte == END_MARK) begin
                        phase_next = PH_EOF;
                    end else if (item.data_byte == MARK_Z) begin
                        phase_next        = PH_HDR2;
                        header_count_next = 3'd0;
                        header_shift_next = 32'd0;
                    end else begin
                        phase_next        = PH_ERR;
                        payload_left_next = 16'd0;
                    end
                end
                PH_HDR2: begin
                    header_shift_next = shifted;
                    header_count_next = count_inc;
                    if (count_inc >= 3'd2) begin
                        header_count_next = 3'd0;
                        header_shift_next = 32'd0;
                        if (header_shift_reg[7:0] != MARK_V) begin
                            phase_next        = PH_ERR;
                            payload_left_next = 16'd0;
                        end else if (item.data_byte == TYPE_STORED) begin
                            block_kind_next = BK_STORED;
                            phase_next      = PH_HDR3;
                        end else if (item.data_byte == TYPE_LZF) begin
                            block_kind_next = BK_LZF;
                            phase_next      = PH_HDR3;
                        end else if (item.data_byte == TYPE_TRAILER) begin
                            block_kind_next = BK_TRAILER;
                            phase_next      = PH_HDR3;
                        end else begin
                            phase_next        = PH_ERR;
                            payload_left_next = 16'd0;
                        end
                    end
                end
                PH_HDR3: begin
                    header_shift_next = shifted;
                    header_count_next = count_inc;
                    if (count_inc >= ((block_kind_reg == BK_STORED) ? 3'd2 : 3'd4)) begin
                        header_count_next = 3'd0;
                        header_shift_next = 32'd0;
                        if (block_kind_reg == BK_STORED) begin
                            block_usize_next  = shifted[15:0];
                            payload_left_next = shifted[15:0];
                            phase_next = (shifted[15:0] != 16'd0) ? PH_DATA : PH_HDR1;
                        end else if (block_kind_reg == BK_LZF) begin
                            block_usize_next    = shifted[15:0];
                            payload_left_next   = shifted[31:16];
                            returned_count_next = 17'd0;
                            if (shifted[31:16] == 16'd0 && shifted[15:0] == 16'd0) begin
                                phase_next = PH_HDR1;
                            end else if (shifted[31:16] == 16'd0 ||
                                         shifted[15:0] == 16'd0) begin
                                phase_next        = PH_ERR;
                                payload_left_next = 16'd0;
                            end else begin
                                phase_next = PH_DATA;
                            end
                        end else begin
                            if (~crc_reg == shifted) begin
                                crc_ok     = 1'b1;
                                phase_next = PH_HDR1;
                            end else begin
                                phase_next        = PH_ERR;
                                payload_left_next = 16'd0;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    result.out_byte   = item.data_byte;
                    result.block_end  = (payload_left_reg == 16'd1);
                    payload_left_next = left_dec;
                    if (block_kind_reg == BK_STORED) begin
                        result.out_kind = OUT_STORED;
                        crc_next        = crc_upd;
                        if (left_dec == 16'd0) phase_next = PH_HDR1;
                    end else begin
                        result.out_kind = OUT_LZF;
                        if (left_dec == 16'd0) phase_next = PH_WAIT;
                    end
                end
                default: begin
                    // stream byte while decompressed bytes are awaited
                    phase_next        = PH_ERR;
                    payload_left_next = 16'd0;
                end
            endcase
        end

        result.expected_size = block_usize_next;
        if (phase_next == PH_ERR)      result.status = ST_ERROR;
        else if (phase_next == PH_EOF) result.status = ST_EOF;
        else if (crc_ok)               result.status = ST_CRC_OK;
        else                           result.status = ST_RUNNING;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_HDR1;
            header_shift_reg   <= 32'd0;
            header_count_reg   <= 3'd0;
            block_kind_reg     <= BK_STORED;
            payload_left_reg   <= 16'd0;
            block_usize_reg    <= 16'd0;
            returned_count_reg <= 17'd0;
            crc_reg            <= CRC_INIT;
        end else if (step) begin
            phase_reg          <= phase_next;
            header_shift_reg   <= header_shift_next;
            header_count_reg   <= header_count_next;
            block_kind_reg     <= block_kind_next;
            payload_left_reg   <= payload_left_next;
            block_usize_reg    <= block_usize_next;
            returned_count_reg <= returned_count_next;
            crc_reg            <= crc_next;
        end
    end

endmodule

// File: src/lzf_container_stream_deframer.sv
// Top level: input register, parser step and result register.
//
// Usage: framed LZF container bytes (mode 0) and bytes handed back by an
// external LZF decompressor (mode 1) enter on the s_ channel, one beat per
// byte. Each input beat yields exactly one result beat on the m_ channel:
// a stored payload byte, a compressed payload byte for the decompressor,
// or no data, with the block's announced size and the stream status.
// A beat accepted into the input register passes the parser step into the
// result register, which drives m_valid. Throughput: one beat per cycle
// unless the receiver stalls; the header step and the bytewise CRC-32
// update both sit in the single stage between input and result register.
// Reset (aresetn low, synchronous) empties both registers, returns the
// parser to waiting for a header and sets the CRC to all ones.
// When the receiver stalls, the result register holds, the input register
// fills with one beat, and s_ready then drops until m_ready returns.
// A format error is sticky until reset and reports status 3 on every beat.
module lzf_container_stream_deframer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lzfd_pkg::lzfd_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lzfd_pkg::lzfd_out_t m_data
);
    import lzfd_pkg::*;

    logic      in_valid_reg;
    lzfd_in_t  in_item_reg;
    logic      out_valid_reg;
    lzfd_out_t out_item_reg;
    lzfd_out_t step_result;
    logic      advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    lzfd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (advance) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_item_reg <= s_data;
        if (advance) out_item_reg <= step_result;
    end

endmodule
